// File: design/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority run queue.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_PEEK = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] task_id;
        logic [7:0] task_priority;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       head_valid;
        logic [7:0] head_id;
        logic [7:0] head_priority;
        logic [5:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
    } slot_t;

endpackage

// File: design/prq_cmd_if.sv
// ----------------------------------------------------------------------------
// prq_cmd_if
// Valid/ready channel carrying one queue command item.
// ----------------------------------------------------------------------------
interface prq_cmd_if;
    import prq_pkg::*;

    logic valid;
    logic ready;
    cmd_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: design/prq_rsp_if.sv
// ----------------------------------------------------------------------------
// prq_rsp_if
// Valid/ready channel carrying one queue result item.
// ----------------------------------------------------------------------------
interface prq_rsp_if;
    import prq_pkg::*;

    logic valid;
    logic ready;
    rsp_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: design/priority_run_queue.sv
// ----------------------------------------------------------------------------
// priority_run_queue
// Run queue of task ids sorted by priority (highest first, ties in arrival
// order) held in a single-port-write / single-port-read slot memory.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     item contents
//  -------  ---  ------------  ---------------------------------------------
//  cmd      in   valid/ready   func, task_id, task_priority
//  rsp      out  valid/ready   status, head_valid, head_id, head_priority,
//                              occupancy
//
//  One slot memory access per cycle drives the timing. Enqueue compares from
//  the tail and moves past up to QUEUE_DEPTH - 1 lower entries; dequeue scans
//  for the id and shifts the later live entries; peek, enqueue into an empty
//  or full queue and dequeue on an empty queue go straight to the head read.
//  cmd.ready is high only while the sequencer is idle.
//  Reset clears the count and the control state; slot contents are not reset.
//  A result waits in the output register while the next command runs; the
//  sequencer stalls in its last step only if that register is still full.
// ----------------------------------------------------------------------------
module priority_run_queue (
    input  logic  clk,
    input  logic  rst_n,
    prq_cmd_if.sink   cmd,
    prq_rsp_if.source rsp
);
    import prq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_ENQ_CMP   = 6'b000010,  // compare new prio against slot[idx-1]
        S_ENQ_PUT   = 6'b000100,  // drop new entry at the head
        S_DEQ_SCAN  = 6'b001000,  // compare slot[idx] id, prefetch idx+1
        S_DEQ_SHIFT = 6'b010000,  // slot[idx] <= slot[idx+1]
        S_HEAD_RD   = 6'b100000   // fetch slot 0, then build result
    } state_t;

    // S_HEAD_RD is followed by a finish step; reuse idle code path is not
    // possible, so track it with one flag.
    state_t           state_reg, state_next;
    logic             finish_reg, finish_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       prio_reg, prio_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_item_reg, rsp_item_next;

    // slot memory
    slot_t            mem [QUEUE_DEPTH];
    slot_t            rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic             wr_en;
    slot_t            wr_data;

    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] idx_p2;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] idx_m2;
    logic             rsp_free;
    slot_t            new_slot;

    assign idx_p1   = idx_reg + CNT_W'(1);
    assign idx_p2   = idx_reg + CNT_W'(2);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign idx_m2   = idx_reg - CNT_W'(2);
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign new_slot = '{id: id_reg, prio: prio_reg};

    assign cmd.ready = (state_reg == S_IDLE) && !finish_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.item  = rsp_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        finish_next    = finish_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        prio_next      = prio_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = new_slot;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (finish_reg)
        begin
            // rd_data_reg holds slot 0 here (rd_addr stays 0)
            if (rsp_free)
            begin
                rsp_valid_next              = 1'b1;
                rsp_item_next.status        = status_reg;
                rsp_item_next.head_valid    = (count_reg != '0);
                rsp_item_next.head_id       = (count_reg != '0) ? rd_data_reg.id : 8'd0;
                rsp_item_next.head_priority = (count_reg != '0) ? rd_data_reg.prio : 8'd0;
                rsp_item_next.occupancy     = 6'(count_reg);
                finish_next                 = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        id_next     = cmd.item.task_id;
                        prio_next   = cmd.item.task_priority;
                        status_next = ST_OK;
                        case (cmd.item.func)
                            FUNC_ENQ:
                            begin
                                if (count_reg == CNT_W'(QUEUE_DEPTH))
                                begin
                                    status_next = ST_FULL;
                                    state_next  = S_HEAD_RD;
                                end
                                else if (count_reg == '0)
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = '0;
                                    wr_data    = '{id: cmd.item.task_id,
                                                   prio: cmd.item.task_priority};
                                    count_next = CNT_W'(1);
                                    state_next = S_HEAD_RD;
                                end
                                else
                                begin
                                    rd_addr    = ADDR_W'(count_reg - CNT_W'(1));
                                    idx_next   = count_reg;
                                    state_next = S_ENQ_CMP;
                                end
                            end
                            FUNC_DEQ:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_next = ST_NOT_FOUND;
                                    state_next  = S_HEAD_RD;
                                end
                                else
                                begin
                                    rd_addr    = '0;
                                    idx_next   = '0;
                                    state_next = S_DEQ_SCAN;
                                end
                            end
                            default:
                            begin
                                // peek, and the unused code behaves the same
                                status_next = (count_reg == '0) ? ST_EMPTY : ST_OK;
                                state_next  = S_HEAD_RD;
                            end
                        endcase
                    end
                end

                S_ENQ_CMP:
                begin
                    // rd_data_reg = slot[idx-1]
                    if (prio_reg > rd_data_reg.prio)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = ADDR_W'(idx_reg);
                        wr_data  = rd_data_reg;
                        idx_next = idx_m1;
                        if (idx_reg == CNT_W'(1))
                        begin
                            state_next = S_ENQ_PUT;
                        end
                        else
                        begin
                            rd_addr = ADDR_W'(idx_m2);
                        end
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(idx_reg);
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_HEAD_RD;
                    end
                end

                S_ENQ_PUT:
                begin
                    wr_en      = 1'b1;
                    wr_addr    = ADDR_W'(idx_reg);
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_HEAD_RD;
                end

                S_DEQ_SCAN:
                begin
                    // rd_data_reg = slot[idx]; prefetch slot[idx+1]
                    rd_addr = ADDR_W'(idx_p1);
                    if (rd_data_reg.id == id_reg)
                    begin
                        if (idx_p1 == count_reg)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_HEAD_RD;
                        end
                        else
                        begin
                            state_next = S_DEQ_SHIFT;
                        end
                    end
                    else if (idx_p1 == count_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_HEAD_RD;
                    end
                    else
                    begin
                        idx_next = idx_p1;
                    end
                end

                S_DEQ_SHIFT:
                begin
                    // rd_data_reg = slot[idx+1]; close the gap at idx
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(idx_reg);
                    wr_data = rd_data_reg;
                    rd_addr = ADDR_W'(idx_p2);
                    if (idx_p2 == count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_HEAD_RD;
                    end
                    else
                    begin
                        idx_next = idx_p1;
                    end
                end

                S_HEAD_RD:
                begin
                    rd_addr     = '0;
                    finish_next = 1'b1;
                    state_next  = S_IDLE;
                end

                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            finish_reg    <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            finish_reg    <= finish_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        id_reg       <= id_next;
        prio_reg     <= prio_next;
        rsp_item_reg <= rsp_item_next;
    end

    // slot memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: tb/prq_order_checker.sv
// ----------------------------------------------------------------------------
// prq_order_checker
// Watches the command and result channels of the run queue. Every accepted
// command is applied to a local sorted copy of the queue; the head, count and
// status that copy gives are compared with each accepted result, in order.
// ----------------------------------------------------------------------------
module prq_order_checker (
    input  logic clk,
    input  logic rst_n,
    prq_cmd_if   cmd,
    prq_rsp_if   rsp,
    output int   mismatches,
    output int   reports_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import prq_pkg::*;

    slot_t       run_slots [QUEUE_DEPTH];
    int unsigned run_len;
    rsp_t        expected_reports [$];

    // Apply one command to the local queue; return the report it must give.
    function automatic rsp_t predict_report(cmd_t c);
        rsp_t        r;
        status_t     st;
        int unsigned pos;
        int          hit;
        hit = -1;
        case (func_t'(c.func))
            FUNC_ENQ:
            begin
                if (run_len >= QUEUE_DEPTH)
                    st = ST_FULL;
                else
                begin
                    // enter at the tail, pass only strictly lower priorities
                    pos = run_len;
                    while (pos > 0 && c.task_priority > run_slots[pos - 1].prio)
                    begin
                        run_slots[pos] = run_slots[pos - 1];
                        pos--;
                    end
                    run_slots[pos].id   = c.task_id;
                    run_slots[pos].prio = c.task_priority;
                    run_len++;
                    st = ST_OK;
                end
            end
            FUNC_DEQ:
            begin
                for (int i = 0; i < run_len && hit < 0; i++)
                    if (run_slots[i].id == c.task_id)
                        hit = i;
                if (hit < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    for (int i = hit; i + 1 < run_len; i++)
                        run_slots[i] = run_slots[i + 1];
                    run_len--;
                    st = ST_OK;
                end
            end
            default:  // peek, and the spare code behaves the same
                st = (run_len == 0) ? ST_EMPTY : ST_OK;
        endcase
        r.status     = st;
        r.head_valid = (run_len > 0);
        r.head_id       = (run_len > 0) ? run_slots[0].id   : 8'h00;
        r.head_priority = (run_len > 0) ? run_slots[0].prio : 8'h00;
        r.occupancy  = 6'(run_len);
        return r;
    endfunction

    task automatic compare_field(string label, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            run_len      = 0;
            mismatches   = 0;
            reports_owed = 0;
            expected_reports.delete();
        end
        else
        begin
            // results always trail their command, so compare before predicting
            if (rsp.valid && rsp.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h",
                             $time, rsp.item);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("status", want.status, rsp.item.status);
                    compare_field("head_valid", want.head_valid, rsp.item.head_valid);
                    compare_field("head_id", want.head_id, rsp.item.head_id);
                    compare_field("head_priority", want.head_priority,
                                  rsp.item.head_priority);
                    compare_field("occupancy", want.occupancy, rsp.item.occupancy);
                end
            end
            if (cmd.valid && cmd.ready)
                expected_reports.push_back(predict_report(cmd.item));
            reports_owed = expected_reports.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the priority run queue with a short directed sequence and then with
// random phases that fill, drain and mix the queue, under random gaps on both
// channels and one long result hold-off. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prq_pkg::*;

    // Unused operation code; the block treats it as a peek.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_AFTER   = 400;  // items sent before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;   // longer than the longest operation

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    prq_cmd_if cmd ();
    prq_rsp_if rsp ();

    int          mismatches;
    int          reports_owed;
    int unsigned items_sent = 0;

    // Ids the stimulus believes are queued; only used to aim dequeues at
    // present ids. Duplicates are kept as separate entries.
    logic [7:0] live_ids [$];

    priority_run_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    prq_order_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .reports_owed (reports_owed)
    );

    always #4 clk = ~clk;

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int unsigned next_gap(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offer one command item and hold it until the block takes it.
    // Called at a rising edge; leaves valid high so that the next call can
    // continue without a bubble.
    task automatic issue(input logic [1:0] op, input logic [7:0] id,
                         input logic [7:0] prio, input int unsigned gap);
        cmd_t c;
        int   hit;
        hit = -1;
        c.func          = op;
        c.task_id       = id;
        c.task_priority = prio;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.item  <= c;
        do
            @(posedge clk);
        while (!cmd.ready);
        items_sent++;
        // track what the queue should hold, for aiming later dequeues
        if (op == FUNC_ENQ && live_ids.size() < QUEUE_DEPTH)
            live_ids.push_back(id);
        else if (op == FUNC_DEQ)
        begin
            foreach (live_ids[i])
                if (hit < 0 && live_ids[i] == id)
                    hit = i;
            if (hit >= 0)
                live_ids.delete(hit);
        end
    endtask

    // Result side: random ready pattern, including long stretches with no
    // stall, and once a long hold-off while the sender keeps offering, so the
    // output register fills and the block drops cmd.ready.
    initial
    begin
        int unsigned run;
        int unsigned r;
        bit          held;
        held = 1'b0;
        rsp.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && items_sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 12);
            rsp.ready <= 1'b1;
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            run = (r < 70) ? 1 : (r < 92) ? $urandom_range(2, 4) : $urandom_range(10, 40);
            rsp.ready <= 1'b0;
            repeat (run) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        phase_t      kind;
        int unsigned pick;
        int unsigned phase_len;
        int unsigned random_sent;
        int unsigned enq_lim;
        int unsigned deq_lim;
        int unsigned prio_mode;
        bit          burst;
        bit          narrow_ids;
        logic [1:0]  op;
        logic [7:0]  id;
        logic [7:0]  prio;

        cmd.valid <= 1'b0;
        cmd.item  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // empty queue: peek, spare code, dequeue of an absent id
        issue(FUNC_PEEK,  8'h00, 8'h00, 0);
        issue(FUNC_SPARE, 8'hFF, 8'hFF, 0);
        issue(FUNC_DEQ,   8'h00, 8'h00, 0);
        // field extremes; the top priority passes the lowest one
        issue(FUNC_ENQ,   8'h00, 8'h00, 0);
        issue(FUNC_ENQ,   8'hFF, 8'hFF, 0);
        // equal priorities stay in arrival order; duplicate id accepted
        issue(FUNC_ENQ,   8'h11, 8'h80, 0);
        issue(FUNC_ENQ,   8'h12, 8'h80, 0);
        issue(FUNC_ENQ,   8'h11, 8'h80, 0);
        issue(FUNC_ENQ,   8'hAA, 8'h55, 0);
        issue(FUNC_PEEK,  8'h5A, 8'hA5, 0);
        issue(FUNC_SPARE, 8'h00, 8'h00, 0);
        // duplicate id: the copy nearer the head goes first
        issue(FUNC_DEQ,   8'h11, 8'h00, 0);
        issue(FUNC_DEQ,   8'h42, 8'h00, 0);
        // remove the head, then a tie with the old head priority
        issue(FUNC_DEQ,   8'hFF, 8'h00, 0);
        issue(FUNC_ENQ,   8'h5A, 8'hFF, 0);
        issue(FUNC_ENQ,   8'hA5, 8'h00, 0);
        // drain in an arbitrary order down to empty
        issue(FUNC_DEQ,   8'h11, 8'h00, 0);
        issue(FUNC_DEQ,   8'h00, 8'h00, 0);
        issue(FUNC_DEQ,   8'h5A, 8'h00, 0);
        issue(FUNC_DEQ,   8'h12, 8'h00, 0);
        issue(FUNC_DEQ,   8'hA5, 8'h00, 0);
        issue(FUNC_DEQ,   8'hAA, 8'h00, 0);
        issue(FUNC_PEEK,  8'h00, 8'h00, 0);

        // ---- random phases ----
        // Fill phases favour enqueues, drain phases favour dequeues aimed at present
        // ids, mixed phases mix both, noise is anything.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            kind = (pick < 35) ? PH_FILL : (pick < 70) ? PH_DRAIN
                 : (pick < 92) ? PH_MIXED : PH_NOISE;
            phase_len  = $urandom_range(10, 60);
            burst      = ($urandom_range(0, 4) == 0);
            narrow_ids = ($urandom_range(0, 2) == 0);   // many duplicate ids
            prio_mode  = $urandom_range(0, 2);
            case (kind)
                PH_FILL:  begin enq_lim = 75; deq_lim = 90; end
                PH_DRAIN: begin enq_lim = 15; deq_lim = 85; end
                default:  begin enq_lim = 40; deq_lim = 80; end
            endcase
            for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                id   = narrow_ids ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
                case (prio_mode)
                    0:       prio = 8'($urandom_range(0, 255));
                    1:       prio = 8'($urandom_range(0, 3));     // mostly ties
                    default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                if (kind == PH_NOISE)
                    op = 2'($urandom_range(0, 3));
                else if (pick < enq_lim)
                    op = FUNC_ENQ;
                else if (pick < deq_lim)
                    op = FUNC_DEQ;
                else
                    op = $urandom_range(0, 1) ? FUNC_PEEK : FUNC_SPARE;
                // most dequeues hit a queued id; the rest are likely misses
                if (op == FUNC_DEQ && kind != PH_NOISE && live_ids.size() > 0
                    && $urandom_range(0, 9) != 0)
                    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                issue(op, id, prio, next_gap(burst));
                random_sent++;
            end
        end

        cmd.valid <= 1'b0;
        @(posedge clk);
        wait (reports_owed == 0);
        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
